/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL. Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property checked at every rising edge of i_clk outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Expression that must never be true outside reset.
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_CLK(label, prop, msg)
`define ASSERT_NEVER(label, expr, msg)

`endif

`endif

/* rtl/cbfs_pkg.sv */
package cbfs_pkg;

    localparam int MAX_BOXES = 64;
    localparam int ADDR_W    = $clog2(MAX_BOXES);
    localparam int CNT_W     = $clog2(MAX_BOXES + 1);

    // Shrink ratios: x offset w/10, y offset 7h/100, new size 4/5.
    localparam int DEN_X  = 10;
    localparam int DEN_Y  = 100;
    localparam int DEN_WH = 5;
    localparam int MUL_Y  = 7;

    // Truncated reciprocals; the estimate is low by at most one.
    localparam int RECIP_X  = (1 << 15) / DEN_X;
    localparam int SHIFT_X  = 15;
    localparam int RECIP_Y  = (1 << 20) / DEN_Y;
    localparam int SHIFT_Y  = 20;
    localparam int RECIP_WH = (1 << 16) / DEN_WH;
    localparam int SHIFT_WH = 16;

    typedef struct packed {
        logic [11:0] box_x;
        logic [11:0] box_y;
        logic [11:0] box_width;
        logic [11:0] box_height;
        logic        last_box;
    } t_in_beat;

    typedef struct packed {
        logic [12:0] out_x;
        logic [12:0] out_y;
        logic [11:0] out_width;
        logic [11:0] out_height;
        logic        last_result;
        logic        none_kept;
        logic        overflow;
    } t_out_beat;

    typedef struct packed {
        logic [11:0] x;
        logic [11:0] y;
        logic [11:0] w;
        logic [11:0] h;
    } t_box;

endpackage

/* rtl/contained_box_filter_shrink_top.sv */
// Channel | Direction | Handshake                 | Beat payload
// in      | input     | i_in_valid / o_in_ready   | i_in_data  (cbfs_pkg::t_in_beat)
// out     | output    | o_out_valid / i_out_ready | o_out_data (cbfs_pkg::t_out_beat)
//
// Loading takes one box per cycle. Once the last box of a set is taken, every stored
// box is checked against all stored boxes through the single read port of the box
// memory. Reset is synchronous and active low; it clears the control state but not
// the memory. A stall on the output holds the filter when a kept box must move into a
// full output register or the final beat must enter it; loading of the next set may
// begin while the final beat still waits.

`include "assert_macros.svh"

module contained_box_filter_shrink_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  cbfs_pkg::t_in_beat   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output cbfs_pkg::t_out_beat  o_out_data
);

    import cbfs_pkg::*;

    // The flow per set: LOAD takes boxes into the memory. For each candidate i,
    // RD reads entry i, CAP holds it, SCAN streams every entry past it, and DEC
    // decides whether it survives. FIN sends the final beat and clears the set.
    typedef enum logic [2:0] {
        S_LOAD,
        S_RD,
        S_CAP,
        S_SCAN,
        S_DEC,
        S_FIN
    } t_state;

    t_state             r_state;
    logic [CNT_W-1:0]   r_count;
    logic               r_ovf;
    logic [CNT_W-1:0]   r_i;
    logic [CNT_W-1:0]   r_j;
    logic [ADDR_W-1:0]  r_rd_idx;
    logic               r_scan_vld;
    logic               r_drop;
    logic               r_pend_vld;
    t_out_beat          r_pend;
    logic               r_out_valid;
    t_out_beat          r_out;

    // Box memory: one write port for loading, one synchronous read port.
    t_box               mem [MAX_BOXES];
    t_box               r_rdata;
    logic [ADDR_W-1:0]  rd_addr;
    t_box               wr_box;

    t_box               r_cand;

    logic               in_fire;
    logic               out_free;
    logic               store_ok;
    logic               contained;
    logic               fin_go;
    logic               out_load;
    logic [CNT_W-1:0]   i_inc;
    t_out_beat          shrunk;
    t_out_beat          none_beat;
    t_out_beat          fin_beat;

    // Shrink arithmetic, three steps: quotient estimate, correction, rounding.
    logic [14:0]        num_y;
    logic [13:0]        num_w;
    logic [13:0]        num_h;
    logic [23:0]        prod_x;
    logic [28:0]        prod_y;
    logic [27:0]        prod_w;
    logic [27:0]        prod_h;
    logic [8:0]         r_qx_est;
    logic [8:0]         r_qy_est;
    logic [11:0]        r_qw_est;
    logic [11:0]        r_qh_est;
    logic [4:0]         rem_x;
    logic [7:0]         rem_y;
    logic [3:0]         rem_w;
    logic [3:0]         rem_h;
    logic [8:0]         r_qx;
    logic [8:0]         r_qy;
    logic [11:0]        r_qw;
    logic [11:0]        r_qh;
    logic [3:0]         r_rx;
    logic [6:0]         r_ry;
    logic [2:0]         r_rw;
    logic [2:0]         r_rh;
    logic               up_x;
    logic               up_y;
    logic               up_w;
    logic               up_h;
    logic [8:0]         rnd_x;
    logic [8:0]         rnd_y;

    assign in_fire     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign store_ok    = r_count < CNT_W'(MAX_BOXES);
    assign i_inc       = r_i + CNT_W'(1);
    assign o_in_ready  = (r_state == S_LOAD);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // A beat enters the output register when a kept box is passed on or the
    // set closes; otherwise the register empties once the receiver takes it.
    assign fin_go   = (r_state == S_FIN) && out_free;
    assign out_load = fin_go ||
                      ((r_state == S_DEC) && !r_drop && r_pend_vld && out_free);

    assign wr_box  = '{x: i_in_data.box_x, y: i_in_data.box_y,
                       w: i_in_data.box_width, h: i_in_data.box_height};
    assign rd_addr = (r_state == S_RD) ? r_i[ADDR_W-1:0] : r_j[ADDR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (in_fire && store_ok) begin
            mem[r_count[ADDR_W-1:0]] <= wr_box;
        end
        r_rdata <= mem[rd_addr];
    end

    // The candidate lies inside the streamed box: the candidate's left and top
    // edges are not before the other's, and its right and bottom not past them.
    assign contained = (r_cand.x >= r_rdata.x) && (r_cand.y >= r_rdata.y) &&
                       ({1'b0, r_cand.x} + {1'b0, r_cand.w} <=
                        {1'b0, r_rdata.x} + {1'b0, r_rdata.w}) &&
                       ({1'b0, r_cand.y} + {1'b0, r_cand.h} <=
                        {1'b0, r_rdata.y} + {1'b0, r_rdata.h});

    // Step one: multiply by the truncated reciprocal and shift.
    assign num_y  = 15'(r_cand.h) * 15'(MUL_Y);
    assign num_w  = {r_cand.w, 2'b00};
    assign num_h  = {r_cand.h, 2'b00};
    assign prod_x = 24'(r_cand.w) * 24'(RECIP_X);
    assign prod_y = 29'(num_y) * 29'(RECIP_Y);
    assign prod_w = 28'(num_w) * 28'(RECIP_WH);
    assign prod_h = 28'(num_h) * 28'(RECIP_WH);

    // Step two: remainders, at most one subtraction of the divisor each.
    assign rem_x = 5'(r_cand.w - 12'(r_qx_est) * 12'(DEN_X));
    assign rem_y = 8'(num_y - 15'(r_qy_est) * 15'(DEN_Y));
    assign rem_w = 4'(num_w - 14'(r_qw_est) * 14'(DEN_WH));
    assign rem_h = 4'(num_h - 14'(r_qh_est) * 14'(DEN_WH));

    always_ff @(posedge i_clk) begin
        if (r_state == S_CAP) begin
            r_cand <= r_rdata;
        end
        r_qx_est <= 9'(prod_x >> SHIFT_X);
        r_qy_est <= 9'(prod_y >> SHIFT_Y);
        r_qw_est <= 12'(prod_w >> SHIFT_WH);
        r_qh_est <= 12'(prod_h >> SHIFT_WH);
        if (rem_x >= 5'(DEN_X)) begin
            r_qx <= r_qx_est + 9'd1;
            r_rx <= 4'(rem_x - 5'(DEN_X));
        end else begin
            r_qx <= r_qx_est;
            r_rx <= 4'(rem_x);
        end
        if (rem_y >= 8'(DEN_Y)) begin
            r_qy <= r_qy_est + 9'd1;
            r_ry <= 7'(rem_y - 8'(DEN_Y));
        end else begin
            r_qy <= r_qy_est;
            r_ry <= 7'(rem_y);
        end
        if (rem_w >= 4'(DEN_WH)) begin
            r_qw <= r_qw_est + 12'd1;
            r_rw <= 3'(rem_w - 4'(DEN_WH));
        end else begin
            r_qw <= r_qw_est;
            r_rw <= 3'(rem_w);
        end
        if (rem_h >= 4'(DEN_WH)) begin
            r_qh <= r_qh_est + 12'd1;
            r_rh <= 3'(rem_h - 4'(DEN_WH));
        end else begin
            r_qh <= r_qh_est;
            r_rh <= 3'(rem_h);
        end
    end

    // Step three: round half to even, then offset the corner.
    assign up_x = ({r_rx, 1'b0} > 5'(DEN_X)) || (({r_rx, 1'b0} == 5'(DEN_X)) && r_qx[0]);
    assign up_y = ({r_ry, 1'b0} > 8'(DEN_Y)) || (({r_ry, 1'b0} == 8'(DEN_Y)) && r_qy[0]);
    assign up_w = ({r_rw, 1'b0} > 4'(DEN_WH)) || (({r_rw, 1'b0} == 4'(DEN_WH)) && r_qw[0]);
    assign up_h = ({r_rh, 1'b0} > 4'(DEN_WH)) || (({r_rh, 1'b0} == 4'(DEN_WH)) && r_qh[0]);
    assign rnd_x = r_qx + 9'(up_x);
    assign rnd_y = r_qy + 9'(up_y);

    always_comb begin
        shrunk             = '0;
        shrunk.out_x       = 13'(r_cand.x) + 13'(rnd_x);
        shrunk.out_y       = 13'(r_cand.y) + 13'(rnd_y);
        shrunk.out_width   = r_qw + 12'(up_w);
        shrunk.out_height  = r_qh + 12'(up_h);
        shrunk.overflow    = r_ovf;
        none_beat             = '0;
        none_beat.last_result = 1'b1;
        none_beat.none_kept   = 1'b1;
        none_beat.overflow    = r_ovf;
        fin_beat              = r_pend;
        fin_beat.last_result  = 1'b1;
    end

    // Control. A kept box waits in r_pend until the next survivor or the end of
    // the set shows whether it is the final beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_i         <= '0;
            r_j         <= '0;
            r_scan_vld  <= 1'b0;
            r_drop      <= 1'b0;
            r_pend_vld  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_scan_vld <= (r_state == S_SCAN) && (r_j < r_count);
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_scan_vld && (r_rd_idx != r_i[ADDR_W-1:0]) && contained) begin
                r_drop <= 1'b1;
            end
            case (r_state)
                S_LOAD: begin
                    if (in_fire) begin
                        if (store_ok) begin
                            r_count <= r_count + CNT_W'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_in_data.last_box) begin
                            r_i     <= '0;
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_CAP;
                end
                S_CAP: begin
                    r_j     <= '0;
                    r_drop  <= 1'b0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (r_j < r_count) begin
                        r_j      <= r_j + CNT_W'(1);
                        r_rd_idx <= r_j[ADDR_W-1:0];
                    end else if (!r_scan_vld) begin
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    if (r_drop || !r_pend_vld || out_free) begin
                        if (!r_drop) begin
                            if (r_pend_vld) begin
                                r_out <= r_pend;
                            end
                            r_pend     <= shrunk;
                            r_pend_vld <= 1'b1;
                        end
                        r_i     <= i_inc;
                        r_state <= (i_inc == r_count) ? S_FIN : S_RD;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out      <= r_pend_vld ? fin_beat : none_beat;
                        r_pend_vld <= 1'b0;
                        r_count    <= '0;
                        r_ovf      <= 1'b0;
                        r_state    <= S_LOAD;
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    `ASSERT_NEVER(a_count_max, r_count > CNT_W'(MAX_BOXES), "box count beyond capacity")
    `ASSERT_CLK(a_scan_range, r_scan_vld |-> (CNT_W'(r_rd_idx) < r_count), "scan read past set")
    `ASSERT_CLK(a_fin_clear, fin_go |=> (r_count == '0) && !r_ovf, "set not cleared")
    `ASSERT_CLK(a_none_last, r_out_valid && r_out.none_kept |-> r_out.last_result, "none not last")
    `ASSERT_NEVER(a_pend_load, r_pend_vld && (r_state == S_LOAD), "kept box left pending")

endmodule
